[hdl/touch_sample_set_filter_assert.svh]
// ---------------------------------------------------------------------------
// Touch sample set filter assertion macros
// Property wrappers for the file that carries concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_SET_FILTER_ASSERT_SVH
`define TOUCH_SAMPLE_SET_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TSSF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tssf assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TSSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tssf assertion failed");

// Next-cycle implication that is also checked across reset.
`define TSSF_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tssf assertion failed");

`endif

[hdl/tssf_pkg.sv]
// ---------------------------------------------------------------------------
// Touch sample set filter package
// Result codes, register map constants and shared control types.
// ---------------------------------------------------------------------------
package tssf_pkg;

   localparam int LIMIT_BITS    = 10;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int INDEX_BITS    = 2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd10;

   // Word index of the error limit register (byte address bit 2).
   localparam logic REG_ERROR_LIMIT = 1'b0;

   // Count value at which the incoming sample closes the set.
   localparam logic [INDEX_BITS-1:0] SET_LAST = 2'd3;

   typedef enum logic [1:0] {
      KIND_STORED,
      KIND_RELEASED,
      KIND_ACCEPTED,
      KIND_REJECTED
   } kind_type;

   typedef struct packed {
      logic                  store;
      logic [INDEX_BITS-1:0] index;
   } store_ctl_type;

   typedef struct packed {
      logic                  stage_valid;
      logic [INDEX_BITS-1:0] count;
   } core_status_type;

endpackage

[hdl/tssf_req_if.sv]
// ---------------------------------------------------------------------------
// Touch sample request channel
// Valid/ready channel carrying one ADC conversion per transfer.
// ---------------------------------------------------------------------------
interface tssf_req_if #(
   parameter int SAMPLE_BITS = 10
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] x_sample;
   logic [SAMPLE_BITS-1:0] y_sample;
   logic                   pen_up;

   modport source (output valid, x_sample, y_sample, pen_up, input ready);
   modport sink   (input valid, x_sample, y_sample, pen_up, output ready);
endinterface

[hdl/tssf_rsp_if.sv]
// ---------------------------------------------------------------------------
// Touch sample response channel
// Valid/ready channel carrying one filter result per transfer.
// ---------------------------------------------------------------------------
interface tssf_rsp_if #(
   parameter int SAMPLE_BITS = 10
) ();
   logic                   valid;
   logic                   ready;
   tssf_pkg::kind_type     result_kind;
   logic [SAMPLE_BITS-1:0] x_position;
   logic [SAMPLE_BITS-1:0] y_position;

   modport source (output valid, result_kind, x_position, y_position, input ready);
   modport sink   (input valid, result_kind, x_position, y_position, output ready);
endinterface

[hdl/touch_sample_set_filter.sv]
// ---------------------------------------------------------------------------
// Touch sample set filter
// Four-sample touchscreen averaging filter with outlier rejection.
// ---------------------------------------------------------------------------
// The filter takes one conversion per clock while its results are accepted and
// gives exactly one result per conversion, held in the result register after
// the conversion leaves the input register. Throughput of one item per cycle is
// set by the single pass through the neighbor-mean adders and limit compares of
// each axis. With a result waiting, one further conversion is still taken
// into the input register. No clearing pass runs after reset; the first set
// starts empty. Program the error limit only while no transfers are pending.
`include "touch_sample_set_filter_assert.svh"

module touch_sample_set_filter #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   tssf_req_if.sink                            req_bus,
   tssf_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tssf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [tssf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [tssf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import tssf_pkg::*;

   logic [LIMIT_BITS-1:0] error_limit;
   core_status_type       status;
   logic                  limit_write;
   logic [LIMIT_BITS-1:0] limit_wdata;
   logic                  rsp_not_accepted;
   logic                  rsp_zero_position;
   logic                  core_full;
   logic                  core_empty;

   tssf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .error_limit (error_limit)
   );

   tssf_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
      .clock       (clock),
      .reset       (reset),
      .error_limit (error_limit),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .status      (status)
   );

   assign limit_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                        && (csr_paddr[2] == REG_ERROR_LIMIT);
   assign limit_wdata = csr_pwdata[LIMIT_BITS-1:0];

   assign rsp_not_accepted  = rsp_bus.valid && (rsp_bus.result_kind != KIND_ACCEPTED);
   assign rsp_zero_position = (rsp_bus.x_position == '0) && (rsp_bus.y_position == '0);
   assign core_full         = status.stage_valid && rsp_bus.valid;
   assign core_empty        = !rsp_bus.valid && !status.stage_valid && (status.count == '0);

   `TSSF_ASSERT_SAME(a_zero_position, clock, reset, rsp_not_accepted, rsp_zero_position)
   `TSSF_ASSERT_SAME(a_stall_only_full, clock, reset, !req_bus.ready, core_full)
   `TSSF_ASSERT_NEXT(a_limit_write, clock, reset, limit_write, error_limit == $past(limit_wdata))
   `TSSF_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, core_empty)

endmodule

[hdl/tssf_csr.sv]
// ---------------------------------------------------------------------------
// Touch sample set filter register block
// APB-style access to the error limit register.
// ---------------------------------------------------------------------------
module tssf_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tssf_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [tssf_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [tssf_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready,
   output logic [tssf_pkg::LIMIT_BITS-1:0]       error_limit
);
   import tssf_pkg::*;

   logic [LIMIT_BITS-1:0] limit_ff;
   logic [LIMIT_BITS-1:0] limit_in;
   logic                  write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_ERROR_LIMIT);

   assign limit_in = write_hit ? csr_pwdata[LIMIT_BITS-1:0] : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_ERROR_LIMIT) begin
         csr_prdata = CSR_DATA_BITS'(limit_ff);
      end
   end

   assign error_limit = limit_ff;

endmodule

[hdl/tssf_axis.sv]
// ---------------------------------------------------------------------------
// Touch sample set filter axis unit
// History of one axis, neighbor-mean checks and four-sample average.
// ---------------------------------------------------------------------------
module tssf_axis #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                             clock,
   input  tssf_pkg::store_ctl_type          ctl,
   input  logic [SAMPLE_BITS-1:0]           sample,
   input  logic [tssf_pkg::LIMIT_BITS-1:0]  error_limit,
   output logic                             axis_ok,
   output logic [SAMPLE_BITS-1:0]           average
);
   import tssf_pkg::*;

   localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

   logic [SAMPLE_BITS-1:0] hist_ff [0:2];
   logic [SAMPLE_BITS+1:0] sum_all;

   function automatic logic near_mean(
      input logic [SAMPLE_BITS-1:0] a,
      input logic [SAMPLE_BITS-1:0] b,
      input logic [SAMPLE_BITS-1:0] c,
      input logic [LIMIT_BITS-1:0]  lim
   );
      logic [SAMPLE_BITS:0]   pair;
      logic [SAMPLE_BITS-1:0] mean;
      logic [SAMPLE_BITS-1:0] diff;
      pair = {1'b0, a} + {1'b0, b};
      mean = pair[SAMPLE_BITS:1];
      diff = (c > mean) ? (c - mean) : (mean - c);
      return CMP_BITS'(diff) <= CMP_BITS'(lim);
   endfunction

   always_ff @(posedge clock) begin
      if (ctl.store) begin
         hist_ff[ctl.index] <= sample;
      end
   end

   assign axis_ok = near_mean(hist_ff[0], hist_ff[1], hist_ff[2], error_limit)
                    && near_mean(hist_ff[1], hist_ff[2], sample, error_limit);

   assign sum_all = (SAMPLE_BITS+2)'(hist_ff[0]) + (SAMPLE_BITS+2)'(hist_ff[1])
                    + (SAMPLE_BITS+2)'(hist_ff[2]) + (SAMPLE_BITS+2)'(sample);
   assign average = sum_all[SAMPLE_BITS+1:2];

endmodule

[hdl/tssf_core.sv]
// ---------------------------------------------------------------------------
// Touch sample set filter core
// Input register, sample count, result selection and result register.
// ---------------------------------------------------------------------------
module tssf_core #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tssf_pkg::LIMIT_BITS-1:0]  error_limit,
   tssf_req_if.sink                         req_bus,
   tssf_rsp_if.source                       rsp_bus,
   output tssf_pkg::core_status_type        status
);
   import tssf_pkg::*;

   logic                   stage_valid_ff, stage_valid_in;
   logic [SAMPLE_BITS-1:0] stage_x_ff, stage_y_ff;
   logic                   stage_up_ff;
   logic [INDEX_BITS-1:0]  count_ff, count_in;
   logic                   out_valid_ff, out_valid_in;
   kind_type               out_kind_ff, kind_in;
   logic [SAMPLE_BITS-1:0] out_x_ff, out_y_ff, x_in, y_in;

   logic                   advance;
   logic                   take;
   store_ctl_type          ctl;
   logic                   x_ok, y_ok;
   logic [SAMPLE_BITS-1:0] x_avg, y_avg;

   assign advance       = stage_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stage_valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   assign ctl.store = advance && !stage_up_ff && (count_ff != SET_LAST);
   assign ctl.index = count_ff;

   tssf_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
      .clock       (clock),
      .ctl         (ctl),
      .sample      (stage_x_ff),
      .error_limit (error_limit),
      .axis_ok     (x_ok),
      .average     (x_avg)
   );

   tssf_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
      .clock       (clock),
      .ctl         (ctl),
      .sample      (stage_y_ff),
      .error_limit (error_limit),
      .axis_ok     (y_ok),
      .average     (y_avg)
   );

   always_comb begin
      kind_in  = KIND_STORED;
      x_in     = '0;
      y_in     = '0;
      count_in = count_ff;
      if (advance) begin
         priority if (stage_up_ff) begin
            kind_in  = KIND_RELEASED;
            count_in = '0;
         end else if (count_ff != SET_LAST) begin
            kind_in  = KIND_STORED;
            count_in = count_ff + 1'b1;
         end else if (x_ok && y_ok) begin
            kind_in  = KIND_ACCEPTED;
            x_in     = x_avg;
            y_in     = y_avg;
            count_in = '0;
         end else begin
            kind_in  = KIND_REJECTED;
            count_in = '0;
         end
      end
   end

   assign stage_valid_in = take || (stage_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_x_ff  <= req_bus.x_sample;
         stage_y_ff  <= req_bus.y_sample;
         stage_up_ff <= req_bus.pen_up;
      end
      if (advance) begin
         out_kind_ff <= kind_in;
         out_x_ff    <= x_in;
         out_y_ff    <= y_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.result_kind = out_kind_ff;
   assign rsp_bus.x_position  = out_x_ff;
   assign rsp_bus.y_position  = out_y_ff;

   assign status.stage_valid = stage_valid_ff;
   assign status.count       = count_ff;

endmodule

[tb/tb_touch_sample_set_filter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Touch sample set filter testbench
// Drives conversions, pen releases and error limit writes into the filter.
// A scoreboard predicts every result and checks the result stream against
// it, with random idling on both sides.
// ---------------------------------------------------------------------------
module tb_touch_sample_set_filter;
   import tssf_pkg::*;

   localparam int SAMPLE_BITS = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_ADDR_BITS-1:0] LIMIT_ADDR = {REG_ERROR_LIMIT, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR = {~REG_ERROR_LIMIT, 2'b00};

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      kind_type   kind;
      sample_type x;
      sample_type y;
   } point_result_type;

   class sample_set_tracker;
      logic [LIMIT_BITS-1:0] limit;
      logic [INDEX_BITS-1:0] stored;
      sample_type            x_seen[3];
      sample_type            y_seen[3];
      point_result_type      expected_points[$];
      int                    fail_count;

      function new();
         limit = LIMIT_RESET;
         stored = '0;
         fail_count = 0;
         for (int i = 0; i < 3; i++) begin
            x_seen[i] = '0;
            y_seen[i] = '0;
         end
      endfunction

      task log_mismatch(input string msg);
         $display("mismatch: %s", msg);
         fail_count++;
      endtask

      function bit near_mean(sample_type a, sample_type b, sample_type c);
         logic [SAMPLE_BITS:0] mean;
         logic [SAMPLE_BITS:0] dev;
         mean = ({1'b0, a} + {1'b0, b}) >> 1;
         dev = ({1'b0, c} > mean) ? {1'b0, c} - mean : mean - {1'b0, c};
         return dev <= {1'b0, limit};
      endfunction

      function bit axis_fits(sample_type h0, sample_type h1, sample_type h2,
                             sample_type last);
         return near_mean(h0, h1, h2) && near_mean(h1, h2, last);
      endfunction

      function void take_register(logic [CSR_ADDR_BITS-1:0] addr,
                                  logic [CSR_DATA_BITS-1:0] data);
         if (addr[2] == REG_ERROR_LIMIT) limit = data[LIMIT_BITS-1:0];
      endfunction

      function void take_conversion(sample_type xs, sample_type ys, logic up);
         point_result_type       r;
         logic [SAMPLE_BITS+1:0] xsum;
         logic [SAMPLE_BITS+1:0] ysum;
         r.kind = KIND_STORED;
         r.x = '0;
         r.y = '0;
         if (up) begin
            stored = '0;
            r.kind = KIND_RELEASED;
         end else if (stored < SET_LAST) begin
            x_seen[stored] = xs;
            y_seen[stored] = ys;
            stored = stored + 1'b1;
         end else begin
            if (axis_fits(x_seen[0], x_seen[1], x_seen[2], xs) &&
                axis_fits(y_seen[0], y_seen[1], y_seen[2], ys)) begin
               xsum = x_seen[0] + x_seen[1] + x_seen[2] + xs;
               ysum = y_seen[0] + y_seen[1] + y_seen[2] + ys;
               r.x = xsum[SAMPLE_BITS+1:2];
               r.y = ysum[SAMPLE_BITS+1:2];
               r.kind = KIND_ACCEPTED;
            end else begin
               r.kind = KIND_REJECTED;
            end
            stored = '0;
         end
         expected_points.push_back(r);
      endfunction

      task match_result(input kind_type k, input sample_type x, input sample_type y);
         point_result_type e;
         if (expected_points.size() == 0) begin
            log_mismatch($sformatf("result kind %0d with none expected", k));
         end else begin
            e = expected_points.pop_front();
            if (k !== e.kind)
               log_mismatch($sformatf("result_kind %0d, expected %0d", k, e.kind));
            if (x !== e.x)
               log_mismatch($sformatf("x_position %0d, expected %0d", x, e.x));
            if (y !== e.y)
               log_mismatch($sformatf("y_position %0d, expected %0d", y, e.y));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   tssf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   tssf_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_ch ();

   sample_set_tracker tracker = new();

   bit snd_steady;
   bit rsp_steady;
   int hold_cycles;
   int sent_count;
   int cycle_count;

   touch_sample_set_filter #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_ch),
      .rsp_bus     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic sample_type clip_sample(int v);
      if (v < 0) return '0;
      if (v > 1023) return '1;
      return sample_type'(v);
   endfunction

   // Picks a value around the mean, often right on or just past the limit.
   function automatic sample_type pick_near(int center, int lim);
      int off;
      case ($urandom_range(0, 7))
         0: off = lim;
         1: off = -lim;
         2: off = lim + 1;
         3: off = -(lim + 1);
         default: off = int'($urandom_range(0, 2 * lim)) - lim;
      endcase
      return clip_sample(center + off);
   endfunction

   task automatic send_conversion(input sample_type xs, input sample_type ys,
                                  input logic up);
      int gap;
      gap = snd_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.x_sample <= xs;
      req_ch.y_sample <= ys;
      req_ch.pen_up   <= up;
      do @(posedge clock); while (!req_ch.ready);
      tracker.take_conversion(xs, ys, up);
      sent_count++;
   endtask

   task automatic send_set(input sample_type xs[4], input sample_type ys[4],
                           input int cut);
      for (int i = 0; i < cut; i++) send_conversion(xs[i], ys[i], 1'b0);
      if (cut < 4) send_conversion(sample_type'($urandom), sample_type'($urandom), 1'b1);
   endtask

   task automatic send_random_set();
      sample_type xs[4];
      sample_type ys[4];
      int         choice;
      int         lim;
      choice = $urandom_range(0, 19);
      lim = int'(tracker.limit);
      if (choice < 3) begin
         repeat ($urandom_range(1, 4))
            send_conversion(sample_type'($urandom), sample_type'($urandom),
                            ($urandom_range(0, 3) == 0));
         send_conversion(sample_type'($urandom), sample_type'($urandom), 1'b1);
      end else begin
         xs[0] = sample_type'($urandom);
         ys[0] = sample_type'($urandom);
         xs[1] = clip_sample(int'(xs[0]) + int'($urandom_range(0, 32)) - 16);
         ys[1] = clip_sample(int'(ys[0]) + int'($urandom_range(0, 32)) - 16);
         xs[2] = pick_near((int'(xs[0]) + int'(xs[1])) / 2, lim);
         ys[2] = pick_near((int'(ys[0]) + int'(ys[1])) / 2, lim);
         xs[3] = pick_near((int'(xs[1]) + int'(xs[2])) / 2, lim);
         ys[3] = pick_near((int'(ys[1]) + int'(ys[2])) / 2, lim);
         send_set(xs, ys, (choice < 5) ? $urandom_range(0, 3) : 4);
      end
   endtask

   task automatic run_random(input int n);
      int goal;
      goal = sent_count + n;
      while (sent_count < goal) send_random_set();
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (tracker.expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.take_register(addr, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_limit();
      logic [CSR_DATA_BITS-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= LIMIT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      if (got !== CSR_DATA_BITS'(tracker.limit))
         tracker.log_mismatch($sformatf("error_limit read %0d, expected %0d",
                                        got, tracker.limit));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limit(input int lim);
      csr_write(LIMIT_ADDR, ($urandom & ~32'h3ff) | CSR_DATA_BITS'(lim));
      csr_check_limit();
   endtask

   task automatic run_directed();
      sample_type xs[4];
      sample_type ys[4];
      send_conversion(10'd0, 10'd0, 1'b1);
      xs = '{10'd0, 10'd0, 10'd0, 10'd0};
      ys = '{10'd0, 10'd0, 10'd0, 10'd0};
      send_set(xs, ys, 4);
      xs = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
      ys = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
      send_set(xs, ys, 4);
      // Both checks land exactly on the default limit of ten.
      xs = '{10'd100, 10'd101, 10'd110, 10'd95};
      ys = '{10'd500, 10'd501, 10'd490, 10'd505};
      send_set(xs, ys, 4);
      xs = '{10'd100, 10'd101, 10'd111, 10'd106};
      ys = '{10'd500, 10'd501, 10'd490, 10'd505};
      send_set(xs, ys, 4);
      xs = '{10'd100, 10'd101, 10'd110, 10'd95};
      ys = '{10'd500, 10'd501, 10'd490, 10'd506};
      send_set(xs, ys, 4);
      xs = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
      ys = '{10'd1023, 10'd1023, 10'd1023, 10'd1023};
      send_set(xs, ys, 2);
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.x_sample <= '0;
      req_ch.y_sample <= '0;
      req_ch.pen_up   <= 1'b0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      snd_steady  = 1'b0;
      rsp_steady  = 1'b0;
      hold_cycles = 0;
      sent_count  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check_limit();
      run_directed();
      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         case (phase)
            0: set_limit(0);
            1: set_limit(1023);
            2: set_limit(1);
            3: set_limit(10);
            4: set_limit($urandom_range(0, 40));
            default: set_limit($urandom_range(0, 1023));
         endcase
         if (phase == 1) begin
            csr_write(SPARE_ADDR, $urandom);
            csr_check_limit();
         end
         snd_steady = (phase == 2);
         rsp_steady = (phase == 2) || (phase == 4);
         if (phase == 3) begin
            // The receiver stops for a long stretch while transfers keep coming.
            hold_cycles = 300;
            snd_steady = 1'b1;
            repeat (6) send_random_set();
            snd_steady = 1'b0;
         end
         run_random(120);
      end
      wait_idle();
      repeat (10) @(posedge clock);
      if (tracker.fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = rsp_steady ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         tracker.match_result(rsp_ch.result_kind, rsp_ch.x_position, rsp_ch.y_position);
      end
   end

endmodule
